[rtl/itr_pkg.sv]
// Shared types and constants for the interpolated table read block.
// Used by every module under rtl; depends on nothing else.
package itr_pkg;

    // Request operation, coded as the command field of an input request.
    typedef enum logic {
        ITR_OP_READ  = 1'b0,
        ITR_OP_WRITE = 1'b1
    } itr_op_t;

    // Configuration register indexes.
    localparam logic [1:0] ITR_CFG_TABLE_PRESENT = 2'd0;
    localparam logic [1:0] ITR_CFG_TABLE_LENGTH  = 2'd1;
    localparam logic [1:0] ITR_CFG_SAMPLE_OFFSET = 2'd2;

    localparam int unsigned ITR_POS_W    = 32;
    localparam int unsigned ITR_LEN_W    = 13;
    localparam int unsigned ITR_WADDR_W  = 12;
    localparam int unsigned ITR_SAMPLE_W = 16;

    // Entries in the queue between the front and the back end.
    localparam int unsigned ITR_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                        present;
        logic [ITR_LEN_W-1:0]        length;
        logic signed [ITR_POS_W-1:0] offset;
    } itr_cfg_t;

endpackage

[rtl/itr_fifo.sv]
// Small request queue between the front end and the back end.
// Depends on itr_pkg for its depth.
module itr_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int unsigned DEPTH = itr_pkg::ITR_QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/itr_front.sv]
// Front end: accepts requests, adds the offset, clamps the index and queues the work.
// Depends on itr_pkg for the operation codes and the configuration struct.
module itr_front #(
    parameter int unsigned TABLE_DEPTH = 4096,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  itr_pkg::itr_cfg_t                          cfg,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_command,
    input  logic signed [itr_pkg::ITR_POS_W-1:0]       s_position,
    input  logic [itr_pkg::ITR_WADDR_W-1:0]            s_write_address,
    input  logic signed [itr_pkg::ITR_SAMPLE_W-1:0]    s_write_value,
    input  logic                                       fifo_full,
    output logic                                       push,
    output logic [2*$clog2(TABLE_DEPTH)+FRAC_BITS+itr_pkg::ITR_SAMPLE_W:0] entry
);

    localparam int unsigned AW    = $clog2(TABLE_DEPTH);
    localparam int unsigned SUM_W = itr_pkg::ITR_POS_W + 1;

    typedef struct packed {
        itr_pkg::itr_op_t                        op;
        logic [AW-1:0]                           addr0;
        logic [AW-1:0]                           addr1;
        logic [FRAC_BITS-1:0]                    frac;
        logic signed [itr_pkg::ITR_SAMPLE_W-1:0] wdata;
    } entry_t;

    localparam logic [SUM_W-1:0]        DEPTH_W = SUM_W'(TABLE_DEPTH);
    localparam logic [SUM_W-1:0]        TWO_W   = SUM_W'(2);
    localparam logic signed [SUM_W-1:0] ONE_POS = SUM_W'(1) << FRAC_BITS;

    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        len_ext;
    logic [SUM_W-1:0]        len_eff;
    logic [SUM_W-1:0]        last_idx;
    logic [SUM_W-1:0]        idx;
    logic                    keep;
    entry_t                  ent;

    assign sum = {s_position[itr_pkg::ITR_POS_W-1], s_position}
               + {cfg.offset[itr_pkg::ITR_POS_W-1], cfg.offset};
    assign idx     = SUM_W'(sum[SUM_W-1:FRAC_BITS]);
    assign len_ext = SUM_W'(cfg.length);

    always_comb begin
        if (len_ext < TWO_W) begin
            len_eff = TWO_W;
        end else if (len_ext > DEPTH_W) begin
            len_eff = DEPTH_W;
        end else begin
            len_eff = len_ext;
        end
    end

    assign last_idx = len_eff - 1'b1;

    always_comb begin
        ent       = '0;
        keep      = 1'b0;
        ent.wdata = s_write_value;
        unique case (itr_pkg::itr_op_t'(s_command))
            itr_pkg::ITR_OP_WRITE: begin
                ent.op    = itr_pkg::ITR_OP_WRITE;
                ent.addr0 = AW'(s_write_address);
                // Addresses past the end of the table are dropped.
                keep      = (SUM_W'(s_write_address) < DEPTH_W);
            end
            itr_pkg::ITR_OP_READ: begin
                ent.op = itr_pkg::ITR_OP_READ;
                keep   = cfg.present;
                // Clamped reads use one entry twice with zero weight.
                if (sum < ONE_POS) begin
                    ent.addr0 = '0;
                    ent.addr1 = '0;
                end else if (idx >= last_idx) begin
                    ent.addr0 = AW'(last_idx);
                    ent.addr1 = AW'(last_idx);
                end else begin
                    ent.addr0 = AW'(idx);
                    ent.addr1 = AW'(idx + 1'b1);
                    ent.frac  = sum[FRAC_BITS-1:0];
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !fifo_full;
    assign push    = s_valid && !fifo_full && keep;
    assign entry   = ent;

endmodule

[rtl/itr_back.sv]
// Back end: owns the sample table, reads two neighbors, interpolates and saturates.
// Depends on itr_pkg for the operation codes and field widths.
module itr_back #(
    parameter int unsigned TABLE_DEPTH = 4096,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    fifo_valid,
    input  logic [2*$clog2(TABLE_DEPTH)+FRAC_BITS+itr_pkg::ITR_SAMPLE_W:0] fifo_data,
    output logic                                    fifo_pop,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [itr_pkg::ITR_SAMPLE_W-1:0] m_sample
);

    localparam int unsigned AW    = $clog2(TABLE_DEPTH);
    localparam int unsigned SW    = itr_pkg::ITR_SAMPLE_W;
    localparam int unsigned PW    = SW + FRAC_BITS + 2;
    localparam int unsigned DW    = PW - FRAC_BITS;
    localparam int unsigned YW    = DW + 1;

    typedef struct packed {
        itr_pkg::itr_op_t     op;
        logic [AW-1:0]        addr0;
        logic [AW-1:0]        addr1;
        logic [FRAC_BITS-1:0] frac;
        logic signed [SW-1:0] wdata;
    } entry_t;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [YW-1:0] SAT_MAX    = YW'((1 << (SW - 1)) - 1);
    localparam logic signed [YW-1:0] SAT_MIN    = -YW'(1 << (SW - 1));

    logic signed [SW-1:0]        table_reg [TABLE_DEPTH];
    entry_t                      head;

    logic                        rd_valid_reg;
    logic signed [SW-1:0]        rd0_reg;
    logic signed [SW-1:0]        rd1_reg;
    logic [FRAC_BITS-1:0]        frac_reg;

    logic                        mul_valid_reg;
    logic signed [SW-1:0]        y0_reg;
    logic signed [PW-1:0]        prod_reg;

    logic                        out_valid_reg;
    logic signed [SW-1:0]        sample_reg;

    logic                        en_rd;
    logic                        en_mul;
    logic                        en_out;
    logic signed [SW:0]          diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PW-1:0]        prod_next;
    logic signed [PW-1:0]        rnd_sum;
    logic signed [DW-1:0]        delta;
    logic signed [YW-1:0]        y_wide;
    logic signed [SW-1:0]        sample_next;

    assign head = fifo_data;

    // Each stage moves when it is empty or the stage after it moves.
    assign en_out   = !out_valid_reg || m_ready;
    assign en_mul   = !mul_valid_reg || en_out;
    assign en_rd    = !rd_valid_reg || en_mul;
    assign fifo_pop = fifo_valid && en_rd;

    assign diff      = {rd1_reg[SW-1], rd1_reg} - {rd0_reg[SW-1], rd0_reg};
    assign frac_s    = {1'b0, frac_reg};
    assign prod_next = PW'(diff) * PW'(frac_s);

    assign rnd_sum = prod_reg + ROUND_HALF;
    assign delta   = rnd_sum[PW-1:FRAC_BITS];
    assign y_wide  = YW'(y0_reg) + YW'(delta);

    always_comb begin
        if (y_wide > SAT_MAX) begin
            sample_next = SAT_MAX[SW-1:0];
        end else if (y_wide < SAT_MIN) begin
            sample_next = SAT_MIN[SW-1:0];
        end else begin
            sample_next = y_wide[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en_rd) begin
                rd_valid_reg <= fifo_pop && (head.op == itr_pkg::ITR_OP_READ);
            end
            if (en_mul) begin
                mul_valid_reg <= rd_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    // Table port: one write or one dual read per popped request.
    always_ff @(posedge aclk) begin
        if (fifo_pop) begin
            unique case (head.op)
                itr_pkg::ITR_OP_WRITE: begin
                    table_reg[head.addr0] <= head.wdata;
                end
                itr_pkg::ITR_OP_READ: begin
                    rd0_reg  <= table_reg[head.addr0];
                    rd1_reg  <= table_reg[head.addr1];
                    frac_reg <= head.frac;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mul && rd_valid_reg) begin
            y0_reg   <= rd0_reg;
            prod_reg <= prod_next;
        end
        if (en_out && mul_valid_reg) begin
            sample_reg <= sample_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_sample = sample_reg;

endmodule

[rtl/interpolated_table_read.sv]
// Top level of the interpolated table read: configuration registers, front end,
// request queue and back end. Depends on itr_pkg, itr_front, itr_fifo and itr_back.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   s_command, s_position, s_write_address,
//                                           s_write_value
//   m_       out        m_valid / m_ready   m_sample
//   cfg_     in         cfg_wr_en           cfg_index, cfg_wr_data
//
// One request is taken per cycle while the queue is not full. A read passes through
// the queue register, the table read, the multiply and the output register. Reset
// clears the queue, the stage valids, the present flag and the offset, and sets the
// length to 4096; the table holds nothing defined until written. A stalled output
// backs up the stages and then the four-entry queue before s_ready falls.
module interpolated_table_read #(
    parameter int unsigned TABLE_DEPTH = 4096,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [1:0]                              cfg_index,
    input  logic [itr_pkg::ITR_POS_W-1:0]           cfg_wr_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_command,
    input  logic signed [itr_pkg::ITR_POS_W-1:0]    s_position,
    input  logic [itr_pkg::ITR_WADDR_W-1:0]         s_write_address,
    input  logic signed [itr_pkg::ITR_SAMPLE_W-1:0] s_write_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [itr_pkg::ITR_SAMPLE_W-1:0] m_sample
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    typedef struct packed {
        itr_pkg::itr_op_t                        op;
        logic [AW-1:0]                           addr0;
        logic [AW-1:0]                           addr1;
        logic [FRAC_BITS-1:0]                    frac;
        logic signed [itr_pkg::ITR_SAMPLE_W-1:0] wdata;
    } entry_t;

    localparam int unsigned EW = $bits(entry_t);

    itr_pkg::itr_cfg_t cfg_reg;
    entry_t            push_entry;
    logic [EW-1:0]     push_data;
    logic [EW-1:0]     pop_data;
    logic              push;
    logic              fifo_full;
    logic              fifo_valid;
    logic              fifo_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.present <= 1'b0;
            cfg_reg.length  <= itr_pkg::ITR_LEN_W'(4096);
            cfg_reg.offset  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                itr_pkg::ITR_CFG_TABLE_PRESENT: begin
                    cfg_reg.present <= cfg_wr_data[0];
                end
                itr_pkg::ITR_CFG_TABLE_LENGTH: begin
                    cfg_reg.length <= cfg_wr_data[itr_pkg::ITR_LEN_W-1:0];
                end
                itr_pkg::ITR_CFG_SAMPLE_OFFSET: begin
                    cfg_reg.offset <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    itr_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_position      (s_position),
        .s_write_address (s_write_address),
        .s_write_value   (s_write_value),
        .fifo_full       (fifo_full),
        .push            (push),
        .entry           (push_data)
    );

    assign push_entry = push_data;

    itr_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_data  (push_data),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .rd_valid (fifo_valid),
        .rd_data  (pop_data)
    );

    itr_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_valid (fifo_valid),
        .fifo_data  (pop_data),
        .fifo_pop   (fifo_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (m_sample)
    );

    // The back end never takes a request from an empty queue.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> fifo_valid)
        else $error("queue popped while empty");

    // A queued read names one entry twice or two neighbors.
    a_read_neighbors: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_entry.op == itr_pkg::ITR_OP_READ) |->
        (push_entry.addr1 == push_entry.addr0) ||
        (push_entry.addr1 == AW'(push_entry.addr0 + 1'b1)))
        else $error("read addresses are not neighbors");

    // A nonzero weight only goes with two distinct neighbors.
    a_frac_interp: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_entry.op == itr_pkg::ITR_OP_READ && push_entry.frac != '0) |->
        (push_entry.addr1 == AW'(push_entry.addr0 + 1'b1)))
        else $error("weighted read without a next entry");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

[dv/tb_interpolated_table_read.sv]
`timescale 1ns / 1ps
// Self-checking testbench for interpolated_table_read: table writes and interpolated reads are
// predicted in-line and compared with the sample stream under random stalls on both channels.
// Depends on itr_pkg and the interpolated_table_read RTL only.
module tb_interpolated_table_read;

    localparam int unsigned DEPTH         = 4096;
    localparam int unsigned FRAC          = 16;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam longint      CYCLE_LIMIT   = 1000000;

    localparam int unsigned POS_W    = itr_pkg::ITR_POS_W;
    localparam int unsigned WADDR_W  = itr_pkg::ITR_WADDR_W;
    localparam int unsigned SAMPLE_W = itr_pkg::ITR_SAMPLE_W;
    localparam int unsigned LEN_W    = itr_pkg::ITR_LEN_W;

    typedef struct packed {
        itr_pkg::itr_op_t           op;
        logic signed [POS_W-1:0]    position;
        logic [WADDR_W-1:0]         address;
        logic signed [SAMPLE_W-1:0] value;
    } table_request_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_wr_en       = 1'b0;
    logic [1:0]                 cfg_index       = itr_pkg::ITR_CFG_TABLE_PRESENT;
    logic [POS_W-1:0]           cfg_wr_data     = '0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic                       s_command       = itr_pkg::ITR_OP_READ;
    logic signed [POS_W-1:0]    s_position      = '0;
    logic [WADDR_W-1:0]         s_write_address = '0;
    logic signed [SAMPLE_W-1:0] s_write_value   = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;

    // Pending requests, the samples still owed by the block, and the shadow table.
    table_request_t             request_q[$];
    logic signed [SAMPLE_W-1:0] sample_q[$];
    logic signed [SAMPLE_W-1:0] table_image[DEPTH];
    bit                         written_map[DEPTH];

    logic                       cfg_present = 1'b0;
    logic [LEN_W-1:0]           cfg_length  = 13'd4096;
    logic signed [POS_W-1:0]    cfg_offset  = '0;

    table_request_t             next_req;
    logic signed [SAMPLE_W-1:0] want_sample;
    int                         fail_count  = 0;
    int                         send_gap    = 0;
    int                         send_calm   = 0;
    int                         recv_stall  = 0;
    int                         recv_calm   = 0;
    longint                     cycle_count = 0;

    interpolated_table_read #(
        .TABLE_DEPTH(DEPTH),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_position     (s_position),
        .s_write_address(s_write_address),
        .s_write_value  (s_write_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned clamp_length(input logic [LEN_W-1:0] length);
        if (length < 2) return 2;
        if (length > DEPTH) return DEPTH;
        return 32'(length);
    endfunction

    // Finds the entry a read lands on. Blend is set when the read falls strictly inside the
    // table and needs the following entry as well.
    function automatic void locate(input logic signed [POS_W-1:0] position,
                                   output int unsigned lo, output bit blend,
                                   output logic [FRAC-1:0] frac);
        logic signed [POS_W:0] sum;
        int unsigned           span;
        int unsigned           idx;
        span  = clamp_length(cfg_length);
        sum   = {position[POS_W-1], position} + {cfg_offset[POS_W-1], cfg_offset};
        idx   = 32'(sum[POS_W-1:FRAC]);
        frac  = sum[FRAC-1:0];
        blend = 1'b0;
        if (sum[POS_W] || idx == 0) begin
            lo = 0;
        end else if (idx >= span - 1) begin
            lo = span - 1;
        end else begin
            lo    = idx;
            blend = 1'b1;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] interp_sample(
            input logic signed [POS_W-1:0] position);
        int unsigned        lo;
        bit                 blend;
        logic [FRAC-1:0]    frac;
        logic signed [16:0] y0;
        logic signed [16:0] diff;
        logic signed [34:0] scaled;
        logic signed [17:0] y;
        locate(position, lo, blend, frac);
        if (!blend) return table_image[lo];
        y0     = 17'(table_image[lo]);
        diff   = 17'(table_image[lo + 1]) - 17'(table_image[lo]);
        // Rounding adds one half before the floor, so halves go toward plus infinity.
        scaled = 35'(diff) * 35'($signed({1'b0, frac})) + (35'sd1 <<< (FRAC - 1));
        y      = 18'(y0) + 18'(scaled >>> FRAC);
        if (y > 18'sd32767) return 16'sh7FFF;
        if (y < -18'sd32768) return 16'sh8000;
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gap(input int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0 || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_write(input logic [WADDR_W-1:0] address,
                              input logic signed [SAMPLE_W-1:0] value);
        table_request_t req;
        req.op       = itr_pkg::ITR_OP_WRITE;
        req.position = $urandom;
        req.address  = address;
        req.value    = value;
        written_map[address] = 1'b1;
        request_q.push_back(req);
    endtask

    // Entries that a read will touch are filled first, so no read ever sees an unwritten word.
    task automatic push_read(input logic signed [POS_W-1:0] position);
        table_request_t  req;
        int unsigned     lo;
        bit              blend;
        logic [FRAC-1:0] frac;
        if (cfg_present) begin
            locate(position, lo, blend, frac);
            if (!written_map[lo]) push_write(WADDR_W'(lo), draw_sample());
            if (blend && !written_map[lo + 1]) push_write(WADDR_W'(lo + 1), draw_sample());
        end
        req.op       = itr_pkg::ITR_OP_READ;
        req.position = position;
        req.address  = WADDR_W'($urandom);
        req.value    = SAMPLE_W'($urandom);
        request_q.push_back(req);
    endtask

    task automatic push_random_read();
        int unsigned span;
        int unsigned idx;
        int unsigned frac;
        int unsigned pick;
        longint      pos;
        span = clamp_length(cfg_length);
        pick = $urandom_range(0, 9);
        if (pick >= 7 || (pick < 5 && span <= 2)) begin
            push_read($urandom);
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            frac = $urandom_range(0, 1) ? 0 : (1 << FRAC) - 1;
        end else begin
            frac = $urandom_range(0, (1 << FRAC) - 1);
        end
        if (pick < 5) begin
            idx = $urandom_range(1, span - 2);
        end else begin
            case ($urandom_range(0, 3))
                0: idx = 0;
                1: idx = span - 2;
                2: idx = span - 1;
                default: idx = span;
            endcase
        end
        // Aim at a table position; fall back to a random one if the offset pushes it out of range.
        pos = (longint'(idx) << FRAC) + frac - longint'(cfg_offset);
        if (pos >= -(longint'(1) << 31) && pos < (longint'(1) << 31)) begin
            push_read(pos[POS_W-1:0]);
        end else begin
            push_read($urandom);
        end
    endtask

    task automatic write_register(input logic [1:0] index, input logic [POS_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (index)
            itr_pkg::ITR_CFG_TABLE_PRESENT: cfg_present = data[0];
            itr_pkg::ITR_CFG_TABLE_LENGTH:  cfg_length  = data[LEN_W-1:0];
            itr_pkg::ITR_CFG_SAMPLE_OFFSET: cfg_offset  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic present, input logic [LEN_W-1:0] length,
                              input logic [POS_W-1:0] offset);
        write_register(itr_pkg::ITR_CFG_TABLE_PRESENT, {{(POS_W-1){1'b0}}, present});
        write_register(itr_pkg::ITR_CFG_TABLE_LENGTH, {{(POS_W-LEN_W){1'b0}}, length});
        write_register(itr_pkg::ITR_CFG_SAMPLE_OFFSET, offset);
    endtask

    // Checked on the falling edge so that the driver's pop at the rising edge has settled.
    task automatic wait_drained();
        @(negedge aclk);
        while (request_q.size() != 0 || s_valid || sample_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic present, input logic [LEN_W-1:0] length,
                             input logic [POS_W-1:0] offset, input int count);
        int unsigned span;
        set_config(present, length, offset);
        span = clamp_length(cfg_length);
        for (int i = 0; i < count; i++) begin
            // Halfway through, the sender holds off until every sample has come back.
            if (i == count / 2) wait_drained();
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1)) begin
                    push_write(WADDR_W'($urandom_range(0, span - 1)), draw_sample());
                end else begin
                    push_write(WADDR_W'($urandom_range(0, DEPTH - 1)), draw_sample());
                end
            end else begin
                push_random_read();
            end
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (request_q.size() > 0) begin
                next_req = request_q.pop_front();
                s_valid         <= 1'b1;
                s_command       <= next_req.op;
                s_position      <= next_req.position;
                s_write_address <= next_req.address;
                s_write_value   <= next_req.value;
                send_gap        <= pick_gap(send_calm);
                send_calm       <= (send_calm > 0) ? send_calm - 1
                                 : (($urandom_range(0, 39) == 0) ? 48 : 0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            recv_calm <= (recv_calm > 0) ? recv_calm - 1
                       : (($urandom_range(0, 199) == 0) ? 150 : 0);
            if (recv_stall > 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap(recv_calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_command == itr_pkg::ITR_OP_WRITE) begin
                    table_image[s_write_address] = s_write_value;
                end else if (cfg_present) begin
                    sample_q.push_back(interp_sample(s_position));
                end
            end
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    fail_count++;
                    $error("sample: expected none, got %0d", m_sample);
                end else begin
                    want_sample = sample_q.pop_front();
                    if (m_sample !== want_sample) begin
                        fail_count++;
                        $error("sample: expected %0d, got %0d", want_sample, m_sample);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset no table is attached, so these reads must stay silent.
        push_read(32'sh0001_8000);
        push_read($urandom);
        wait_drained();

        set_config(1'b1, 13'd8, '0);
        push_write(0, 16'sh8000);
        push_write(1, 16'sh7FFF);
        push_write(2, 16'sh8000);
        push_write(3, 16'sh0000);
        push_write(4, 16'shFFFF);
        push_write(5, 16'sh0001);
        push_write(6, 16'sh7FFF);
        push_write(7, 16'sh1234);
        push_write(WADDR_W'(DEPTH - 1), 16'sh7FFF);
        push_read(32'sh8000_0000);
        push_read(32'sh7FFF_FFFF);
        push_read(32'sh0000_0000);
        push_read(32'sh0000_FFFF);
        push_read(32'sh0001_0000);
        // A full-scale swing between the extremes, then a swing from the minimum to zero.
        push_read(32'sh0001_8000);
        push_read(32'sh0002_8000);
        // Exact halves: -0.5 LSB rounds up to zero.
        push_read(32'sh0003_8000);
        push_read(32'sh0004_8000);
        push_read(32'sh0005_8000);
        push_read(32'sh0006_FFFF);
        push_read(32'sh0007_0000);
        wait_drained();

        run_phase(1'b1, 13'd2, '0, 140);
        run_phase(1'b1, 13'd16, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000, 150);
        run_phase(1'b0, 13'd64, '0, 60);
        run_phase(1'b1, 13'd4096, 32'h7FFF_FFFF, 150);
        run_phase(1'b1, 13'd8191, 32'h8000_0000, 120);
        run_phase(1'b1, 13'd0, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000, 140);
        run_phase(1'b1, 13'd1, $urandom, 120);
        run_phase(1'b1, 13'd100, $urandom, 150);
        run_phase(1'b1, 13'd5000, '0, 150);
        run_phase(1'b1, 13'd33, 32'hFFFD_8000, 170);

        if (fail_count == 0 && sample_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
